// ----- src/assert_macros.svh -----
// Assertion macros for the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MTP_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MTP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mtp_pkg.sv -----
// Package with types, constants, command codes and tempering for the MT19937 generator.
package mtp_pkg;

  localparam int WORD_W  = 32;
  localparam int STATE_N = 624;
  localparam int SHIFT_M = 397;
  localparam int IDX_W   = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [1:0]        op_t;
  typedef logic [3:0]        act_t;

  localparam idx_t IDX_FULL  = idx_t'(STATE_N);
  localparam idx_t IDX_LAST  = idx_t'(STATE_N - 1);
  localparam idx_t IDX_WRAP  = idx_t'(STATE_N - SHIFT_M);
  localparam idx_t IDX_SHIFT = idx_t'(SHIFT_M);

  localparam word_t TWIST_XOR          = 32'h9908_b0df;
  localparam word_t UPPER_MASK         = 32'h8000_0000;
  localparam word_t LOWER_MASK         = 32'h7fff_ffff;
  localparam word_t INIT_MULT          = 32'd1812433253;
  localparam word_t TEMPER_B           = 32'h9d2c_5680;
  localparam word_t TEMPER_C           = 32'hefc6_0000;
  localparam word_t DEFAULT_SEED_RESET = 32'd5489;

  localparam op_t OP_SEED   = 2'd0;
  localparam op_t OP_DRAW32 = 2'd1;
  localparam op_t OP_DRAW64 = 2'd2;

  localparam act_t ACT_NONE        = 4'd0;
  localparam act_t ACT_CAPTURE     = 4'd1;
  localparam act_t ACT_SEED_START  = 4'd2;
  localparam act_t ACT_SEED_MUL    = 4'd3;
  localparam act_t ACT_SEED_WRITE  = 4'd4;
  localparam act_t ACT_REGEN_START = 4'd5;
  localparam act_t ACT_REGEN_FIRST = 4'd6;
  localparam act_t ACT_REGEN_READ  = 4'd7;
  localparam act_t ACT_REGEN_WRITE = 4'd8;
  localparam act_t ACT_DRAW_READ   = 4'd9;
  localparam act_t ACT_TAKE_HIGH   = 4'd10;
  localparam act_t ACT_TAKE_LOW    = 4'd11;

  typedef struct packed {
    act_t action;
    logic from_default;
    logic single_word;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic index_full;
    logic cnt_last;
  } status_t;

  function automatic word_t temper(word_t w);
    word_t r;
    r = w ^ (w >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage

// ----- src/mersenne_twister_prng.sv -----
// Top level of the MT19937 generator: controller, datapath and checks.
// A 32-bit draw steps through check, word read and take; a 64-bit draw does so twice, high word first.
// Every 624 words, the draw that finds the state used up first runs the twist over the whole state.
// A seed request is bound by the single multiplier stepping through 623 words, a multiply and a write each.
// The first draw without a prior seed first seeds from default_seed. New requests stall until idle.
// Synchronous reset clears control, sets default_seed to 5489 and leaves the state memory as is.
`include "assert_macros.svh"

module mersenne_twister_prng (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  mtp_pkg::cmd_t    cmd;
  mtp_pkg::status_t status;

  mtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mtp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .status       (status),
    .random_value (random_value)
  );

  `MTP_ASSERT_IMPLY(a_draw_ready, clk, rst, cmd.action == mtp_pkg::ACT_DRAW_READ, status.seeded && !status.index_full, "Word read while the state is unseeded or used up.")
  `MTP_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.action == mtp_pkg::ACT_TAKE_LOW, !out_valid, "Result written over a pending result.")
  `MTP_ASSERT_NEXT(a_take_valid, clk, rst, cmd.action == mtp_pkg::ACT_TAKE_LOW, out_valid, "Final word taken without raising out_valid.")
  `MTP_ASSERT_NEXT(a_regen_wrap, clk, rst, cmd.action == mtp_pkg::ACT_REGEN_WRITE && status.cnt_last, !status.index_full, "Word index not restarted after the twist.")

endmodule

// ----- src/mtp_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                         rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/mtp_datapath.sv -----
// Datapath: state memory, seeding multiplier, twist and tempering logic, output register.
module mtp_datapath (
  input  logic             clk,
  input  logic             rst,
  input  mtp_pkg::cmd_t    cmd,
  input  logic [31:0]      seed_value,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  output mtp_pkg::status_t status,
  output logic [63:0]      random_value
);

  mtp_pkg::word_t default_seed;
  mtp_pkg::word_t seed_hold;
  mtp_pkg::word_t prev;
  mtp_pkg::word_t product;
  mtp_pkg::word_t cur;
  mtp_pkg::word_t high_word;
  mtp_pkg::idx_t  cnt;
  mtp_pkg::idx_t  word_index;
  logic           seeded;

  logic           we;
  mtp_pkg::idx_t  waddr;
  mtp_pkg::word_t wdata;
  mtp_pkg::idx_t  raddr_a;
  mtp_pkg::idx_t  raddr_b;
  mtp_pkg::word_t rd_a;
  mtp_pkg::word_t rd_b;

  mtp_pkg::word_t seed_src;
  mtp_pkg::word_t seed_sum;
  mtp_pkg::word_t mix;
  mtp_pkg::word_t y;
  mtp_pkg::word_t twist;
  mtp_pkg::word_t tempered;
  mtp_pkg::idx_t  nxt_addr;
  mtp_pkg::idx_t  far_addr;

  mtp_ram #(
    .WIDTH(mtp_pkg::WORD_W),
    .DEPTH(mtp_pkg::STATE_N)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  assign seed_src = cmd.from_default ? default_seed : seed_hold;
  assign seed_sum = product + mtp_pkg::word_t'(cnt);
  assign mix      = prev ^ (prev >> 30);
  assign y        = (cur & mtp_pkg::UPPER_MASK) | (rd_a & mtp_pkg::LOWER_MASK);
  assign twist    = rd_b ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_XOR : '0);
  assign tempered = mtp_pkg::temper(rd_a);
  assign nxt_addr = (cnt == mtp_pkg::IDX_LAST) ? '0 : cnt + mtp_pkg::idx_t'(1);
  assign far_addr = (cnt < mtp_pkg::IDX_WRAP) ? cnt + mtp_pkg::IDX_SHIFT
                                              : cnt - mtp_pkg::IDX_WRAP;

  assign status.seeded     = seeded;
  assign status.index_full = (word_index == mtp_pkg::IDX_FULL);
  assign status.cnt_last   = (cnt == mtp_pkg::IDX_LAST);

  always_comb begin
    we      = 1'b0;
    waddr   = cnt;
    wdata   = seed_sum;
    raddr_a = word_index;
    raddr_b = far_addr;
    unique case (cmd.action)
      mtp_pkg::ACT_SEED_START: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed_src;
      end
      mtp_pkg::ACT_SEED_WRITE: begin
        we = 1'b1;
      end
      mtp_pkg::ACT_REGEN_START: begin
        raddr_a = '0;
      end
      mtp_pkg::ACT_REGEN_READ: begin
        raddr_a = nxt_addr;
      end
      mtp_pkg::ACT_REGEN_WRITE: begin
        we    = 1'b1;
        wdata = twist;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_seed <= mtp_pkg::DEFAULT_SEED_RESET;
      word_index   <= mtp_pkg::IDX_FULL;
      seeded       <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_seed <= cfg_wdata;
      end
      case (cmd.action) inside
        mtp_pkg::ACT_SEED_WRITE: begin
          if (cnt == mtp_pkg::IDX_LAST) begin
            word_index <= mtp_pkg::IDX_FULL;
            seeded     <= 1'b1;
          end
        end
        mtp_pkg::ACT_REGEN_WRITE: begin
          if (cnt == mtp_pkg::IDX_LAST) begin
            word_index <= '0;
          end
        end
        mtp_pkg::ACT_TAKE_HIGH, mtp_pkg::ACT_TAKE_LOW: begin
          word_index <= word_index + mtp_pkg::idx_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.action)
      mtp_pkg::ACT_CAPTURE: begin
        seed_hold <= seed_value;
      end
      mtp_pkg::ACT_SEED_START: begin
        prev <= seed_src;
        cnt  <= mtp_pkg::idx_t'(1);
      end
      mtp_pkg::ACT_SEED_MUL: begin
        product <= mtp_pkg::word_t'(mtp_pkg::INIT_MULT * mix);
      end
      mtp_pkg::ACT_SEED_WRITE: begin
        prev <= seed_sum;
        cnt  <= cnt + mtp_pkg::idx_t'(1);
      end
      mtp_pkg::ACT_REGEN_START: begin
        cnt <= '0;
      end
      mtp_pkg::ACT_REGEN_FIRST: begin
        cur <= rd_a;
      end
      mtp_pkg::ACT_REGEN_WRITE: begin
        cur <= rd_a;
        cnt <= cnt + mtp_pkg::idx_t'(1);
      end
      mtp_pkg::ACT_TAKE_HIGH: begin
        high_word <= tempered;
      end
      mtp_pkg::ACT_TAKE_LOW: begin
        random_value <= {(cmd.single_word ? mtp_pkg::word_t'(0) : high_word), tempered};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/mtp_ctrl.sv -----
// Controller state machine that sequences seeding, regeneration and draws.
module mtp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       operation,
  input  logic             out_stall,
  input  mtp_pkg::status_t status,
  output logic             in_stall,
  output logic             out_valid,
  output mtp_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_CHECK       = 4'd1;
  localparam logic [3:0] ST_SEED_START  = 4'd2;
  localparam logic [3:0] ST_SEED_MUL    = 4'd3;
  localparam logic [3:0] ST_SEED_WRITE  = 4'd4;
  localparam logic [3:0] ST_REGEN_START = 4'd5;
  localparam logic [3:0] ST_REGEN_FIRST = 4'd6;
  localparam logic [3:0] ST_REGEN_READ  = 4'd7;
  localparam logic [3:0] ST_REGEN_WRITE = 4'd8;
  localparam logic [3:0] ST_DRAW_READ   = 4'd9;
  localparam logic [3:0] ST_DRAW_TAKE   = 4'd10;

  logic [3:0]       state;
  logic [3:0]       state_next;
  mtp_pkg::op_t     op_reg;
  mtp_pkg::op_t     op_reg_next;
  logic             second;
  logic             second_next;
  logic             from_default;
  logic             from_default_next;
  logic             final_word;
  logic             out_free;

  assign final_word = (op_reg == mtp_pkg::OP_DRAW32) || second;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);

  always_comb begin
    state_next        = state;
    op_reg_next       = op_reg;
    second_next       = second;
    from_default_next = from_default;
    cmd.action        = mtp_pkg::ACT_NONE;
    cmd.from_default  = from_default;
    cmd.single_word   = (op_reg == mtp_pkg::OP_DRAW32);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.action        = mtp_pkg::ACT_CAPTURE;
          op_reg_next       = operation;
          second_next       = 1'b0;
          from_default_next = 1'b0;
          case (operation) inside
            mtp_pkg::OP_SEED: begin
              state_next = ST_SEED_START;
            end
            mtp_pkg::OP_DRAW32, mtp_pkg::OP_DRAW64: begin
              state_next = ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (!status.seeded) begin
          from_default_next = 1'b1;
          state_next        = ST_SEED_START;
        end else if (status.index_full) begin
          state_next = ST_REGEN_START;
        end else begin
          state_next = ST_DRAW_READ;
        end
      end
      ST_SEED_START: begin
        cmd.action = mtp_pkg::ACT_SEED_START;
        state_next = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        cmd.action = mtp_pkg::ACT_SEED_MUL;
        state_next = ST_SEED_WRITE;
      end
      ST_SEED_WRITE: begin
        cmd.action = mtp_pkg::ACT_SEED_WRITE;
        if (status.cnt_last) begin
          state_next = (op_reg == mtp_pkg::OP_SEED) ? ST_IDLE : ST_CHECK;
        end else begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_REGEN_START: begin
        cmd.action = mtp_pkg::ACT_REGEN_START;
        state_next = ST_REGEN_FIRST;
      end
      ST_REGEN_FIRST: begin
        cmd.action = mtp_pkg::ACT_REGEN_FIRST;
        state_next = ST_REGEN_READ;
      end
      ST_REGEN_READ: begin
        cmd.action = mtp_pkg::ACT_REGEN_READ;
        state_next = ST_REGEN_WRITE;
      end
      ST_REGEN_WRITE: begin
        cmd.action = mtp_pkg::ACT_REGEN_WRITE;
        state_next = status.cnt_last ? ST_DRAW_READ : ST_REGEN_READ;
      end
      ST_DRAW_READ: begin
        if (!final_word || out_free) begin
          cmd.action = mtp_pkg::ACT_DRAW_READ;
          state_next = ST_DRAW_TAKE;
        end
      end
      ST_DRAW_TAKE: begin
        if (final_word) begin
          cmd.action = mtp_pkg::ACT_TAKE_LOW;
          state_next = ST_IDLE;
        end else begin
          cmd.action  = mtp_pkg::ACT_TAKE_HIGH;
          second_next = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op_reg       <= mtp_pkg::OP_SEED;
      second       <= 1'b0;
      from_default <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      op_reg       <= op_reg_next;
      second       <= second_next;
      from_default <= from_default_next;
      if (cmd.action == mtp_pkg::ACT_TAKE_LOW) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
